/* hdl/pcpolar_pkg.sv */
// ----------------------------------------------------------------------------
// pcpolar_pkg
// Shared types, constants and the CORDIC gain for the polar minimum-range scan.
// ----------------------------------------------------------------------------
package pcpolar_pkg;

  localparam int ANGLE_BINS_DEF   = 1440;
  localparam int COORD_WIDTH_DEF  = 24;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int FIELD_W = 24;   // width of the coordinate fields on the port
  localparam int ENT_W   = 40;   // queue entry width for pre-rotated x and y
  localparam int RANGE_W = 24;
  localparam int BINF_W  = 11;

  localparam logic [RANGE_W-1:0] RANGE_FULL = '1;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [31:0] ANG_ZERO = 32'h0000_0000;
  localparam logic [31:0] ANG_PI   = 32'h8000_0000;
  localparam logic [31:0] ANG_PI2  = 32'h4000_0000;
  localparam logic [31:0] ANG_NPI2 = 32'hC000_0000;

  // atan(2^-i) as a binary angle, one full turn = 2^32
  localparam logic [31:0] ATAN_TAB [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef enum logic [1:0] {
    K_READ,
    K_AXIS,
    K_ROT
  } kind_t;

  typedef struct packed {
    logic                      opcode;
    logic signed [FIELD_W-1:0] x_coord;
    logic signed [FIELD_W-1:0] y_coord;
    logic [BINF_W-1:0]         read_bin;
  } req_t;

  typedef struct packed {
    logic [RANGE_W-1:0] bin_range;
    logic               bin_hit;
    logic [BINF_W-1:0]  bin_number;
  } res_t;

  typedef struct packed {
    kind_t                   kind;
    logic signed [ENT_W-1:0] cx;
    logic signed [ENT_W-1:0] cy;
    logic [31:0]             z;
    logic [RANGE_W-1:0]      range;
    logic [BINF_W-1:0]       read_bin;
  } entry_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [1:0] count;
  } queue_status_t;

  typedef struct packed {
    logic clearing;
    logic idle;
  } back_status_t;

  // CORDIC gain in Q30: product of sqrt(1 + 4^-i), integer square root at the end
  function automatic logic [63:0] cordic_gain(input int steps);
    logic [63:0] g;
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] b;
    g = 64'd1 << 30;
    for (int i = 0; i < 24; i++) begin
      if (i < steps) g = g + (g >> (2 * i));
    end
    n = g << 30;
    res = '0;
    for (int k = 31; k >= 0; k--) begin
      b = 64'd1 << (2 * k);
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

endpackage

/* hdl/pcpolar_front.sv */
// ----------------------------------------------------------------------------
// pcpolar_front
// Classifies a request: bin read, point on an axis, or point needing CORDIC,
// and pre-rotates left half plane points by pi.
// ----------------------------------------------------------------------------
module pcpolar_front #(
  parameter int COORD_WIDTH = pcpolar_pkg::COORD_WIDTH_DEF
) (
  input  pcpolar_pkg::req_t   cmd,
  output pcpolar_pkg::entry_t entry
);
  import pcpolar_pkg::*;

  localparam int DW = COORD_WIDTH + 7;

  logic [COORD_WIDTH-1:0] xr;
  logic [COORD_WIDTH-1:0] yr;
  logic signed [DW-1:0]   xs;
  logic signed [DW-1:0]   ys;
  logic signed [DW-1:0]   xm;
  logic signed [DW-1:0]   ym;
  logic [DW-1:0]          mag;

  assign xr = COORD_WIDTH'($unsigned(cmd.x_coord));
  assign yr = COORD_WIDTH'($unsigned(cmd.y_coord));
  assign xs = DW'($signed(xr));
  assign ys = DW'($signed(yr));
  assign xm = xs <<< 4;
  assign ym = ys <<< 4;

  always_comb begin
    entry          = '0;
    entry.read_bin = cmd.read_bin;
    mag            = '0;
    if (cmd.opcode == OP_READ) begin
      entry.kind = K_READ;
    end else if (ys == '0 || xs == '0) begin
      entry.kind = K_AXIS;
      if (ys == '0) begin
        mag     = xs[DW-1] ? DW'(-xs) : DW'(xs);
        entry.z = xs[DW-1] ? ANG_PI : ANG_ZERO;
      end else begin
        mag     = ys[DW-1] ? DW'(-ys) : DW'(ys);
        entry.z = ys[DW-1] ? ANG_NPI2 : ANG_PI2;
      end
      entry.range = (mag > DW'(RANGE_FULL)) ? RANGE_FULL : RANGE_W'(mag);
    end else begin
      entry.kind = K_ROT;
      if (xs[DW-1]) begin
        entry.cx = ENT_W'(-xm);
        entry.cy = ENT_W'(-ym);
        entry.z  = ANG_PI;
      end else begin
        entry.cx = ENT_W'(xm);
        entry.cy = ENT_W'(ym);
        entry.z  = ANG_ZERO;
      end
    end
  end

endmodule

/* hdl/pcpolar_queue.sv */
// ----------------------------------------------------------------------------
// pcpolar_queue
// Two-entry queue between the classifier and the scan engine.
// ----------------------------------------------------------------------------
module pcpolar_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  pcpolar_pkg::entry_t        din,
  input  logic                       pop,
  output pcpolar_pkg::entry_t        dout,
  output pcpolar_pkg::queue_status_t status
);
  import pcpolar_pkg::*;

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign dout         = slots[rd_ptr];
  assign status.count = count;
  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= din;
        wr_ptr        <= ~wr_ptr;
      end
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

/* hdl/pcpolar_back.sv */
// ----------------------------------------------------------------------------
// pcpolar_back
// Scan engine: CORDIC vectoring, range scaling by the gain, angle binning and
// the read-modify-write of the bin store.
// ----------------------------------------------------------------------------
module pcpolar_back #(
  parameter int ANGLE_BINS   = pcpolar_pkg::ANGLE_BINS_DEF,
  parameter int COORD_WIDTH  = pcpolar_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = pcpolar_pkg::CORDIC_STEPS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_empty,
  input  pcpolar_pkg::entry_t       q_head,
  output logic                      pop,
  output logic                      done,
  output pcpolar_pkg::res_t         result,
  output pcpolar_pkg::back_status_t status
);
  import pcpolar_pkg::*;

  localparam int DW = COORD_WIDTH + 7;
  localparam int NW = (DW + 27 > 57) ? DW + 27 : 57;
  localparam int BW = $clog2(ANGLE_BINS);
  localparam int SW = $clog2(CORDIC_STEPS);
  localparam int PW = 32 + BW + 1;
  localparam logic [63:0]   GAIN   = cordic_gain(CORDIC_STEPS);
  localparam logic [63:0]   RECIP  = (64'd1 << 55) / GAIN;
  localparam logic [NW-1:0] G_HALF = NW'(GAIN >> 1);
  localparam logic [NW-1:0] G_ONE  = NW'(GAIN);
  localparam logic [NW-1:0] G_TWO  = NW'(GAIN << 1);
  localparam logic [NW-1:0] DVS0   = NW'(GAIN << 24);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_ROT, S_DIV, S_BIN, S_FETCH, S_UPD, S_RDOUT
  } state_t;

  state_t               state;
  logic signed [DW-1:0] cx;
  logic signed [DW-1:0] cy;
  logic [31:0]          zz;
  logic [SW-1:0]        step;
  logic [NW-1:0]        rem;
  logic [1:0]           dcnt;
  logic [24:0]          qhat;
  logic [RANGE_W-1:0]   range_r;
  logic [BW-1:0]        bin_idx;
  logic [BW-1:0]        clr_idx;
  logic [24:0]          rd_data;
  logic [24:0]          mem [ANGLE_BINS];
  logic                 rdmode;

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic [NW-1:0]        xf_num;
  logic [55:0]          est_prod;
  logic [55:0]          back_prod;
  logic [24:0]          qfix;
  logic [31:0]          zbias;
  logic [PW-1:0]        prod;
  logic                 upd;
  logic                 wr_en;
  logic [BW-1:0]        wr_addr;
  logic [24:0]          wr_data;

  assign dx        = cy >>> step;
  assign dy        = cx >>> step;
  assign xf_num    = ((cx[DW-1] ? NW'(0) : NW'($unsigned(cx))) << 26) + G_HALF;
  // quotient estimate from the top bits, at most two short of the true value
  assign est_prod  = 56'(rem[54:24]) * 56'(RECIP[24:0]);
  assign back_prod = 56'(qhat) * 56'(GAIN[30:0]);
  assign qfix      = qhat + ((rem >= G_TWO) ? 25'd2 : (rem >= G_ONE) ? 25'd1 : 25'd0);
  assign zbias     = zz + ANG_PI;
  assign prod      = PW'(zbias) * PW'(ANGLE_BINS);
  assign upd       = !rd_data[24] || (range_r < rd_data[23:0]);

  assign pop             = (state == S_IDLE) && !q_empty;
  assign status.clearing = (state == S_CLEAR);
  assign status.idle     = (state == S_IDLE);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = bin_idx;
    wr_data = '0;
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx;
      end
      S_UPD: begin
        wr_en   = upd;
        wr_data = {1'b1, range_r};
      end
      S_RDOUT: wr_en = 1'b1;
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[bin_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == BW'(ANGLE_BINS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (!q_empty) begin
            cx      <= DW'(q_head.cx);
            cy      <= DW'(q_head.cy);
            zz      <= q_head.z;
            range_r <= q_head.range;
            step    <= '0;
            result.bin_number <= q_head.read_bin;
            case (q_head.kind)
              K_READ: begin
                if (32'(q_head.read_bin) < 32'(ANGLE_BINS)) begin
                  bin_idx <= BW'(q_head.read_bin);
                  state   <= S_FETCH;
                end else begin
                  // out of range: report no return, touch nothing
                  result.bin_range <= '0;
                  result.bin_hit   <= 1'b0;
                  done             <= 1'b1;
                end
              end
              K_AXIS:  state <= S_BIN;
              K_ROT:   state <= S_ROT;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_ROT: begin
          if (!cy[DW-1]) begin
            cx <= cx + dx;
            cy <= cy - dy;
            zz <= zz + ATAN_TAB[5'(step)];
          end else begin
            cx <= cx - dx;
            cy <= cy + dy;
            zz <= zz - ATAN_TAB[5'(step)];
          end
          step <= step + 1'b1;
          if (step == SW'(CORDIC_STEPS - 1)) begin
            dcnt  <= 2'd0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // saturation check, reciprocal estimate, remainder, then correct
          case (dcnt)
            2'd0: begin
              rem  <= xf_num;
              dcnt <= 2'd1;
              if (xf_num >= DVS0) begin
                range_r <= RANGE_FULL;
                state   <= S_BIN;
              end
            end
            2'd1: begin
              qhat <= est_prod[55:31];
              dcnt <= 2'd2;
            end
            2'd2: begin
              rem  <= rem - NW'(back_prod);
              dcnt <= 2'd3;
            end
            default: begin
              range_r <= RANGE_W'(qfix);
              state   <= S_BIN;
            end
          endcase
        end
        S_BIN: begin
          bin_idx <= BW'(prod >> 32);
          state   <= S_FETCH;
        end
        // the fetch state branches on what started the access
        S_FETCH: state <= rdmode ? S_RDOUT : S_UPD;
        S_UPD:   state <= S_IDLE;
        S_RDOUT: begin
          result.bin_range <= rd_data[24] ? rd_data[23:0] : '0;
          result.bin_hit   <= rd_data[24];
          done             <= 1'b1;
          state            <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // set when the current access is a bin read rather than a point update
  always_ff @(posedge clk) begin
    if (rst) begin
      rdmode <= 1'b0;
    end else if (state == S_IDLE && !q_empty) begin
      rdmode <= (q_head.kind == K_READ);
    end
  end

endmodule

/* hdl/point_cloud_to_polar_min_scan_top.sv */
// ----------------------------------------------------------------------------
// point_cloud_to_polar_min_scan_top
// Angular minimum-range scan built from a stream of planar points.
// ----------------------------------------------------------------------------
//  channel   signals                   direction  meaning
//  request   start, busy, cmd          in; busy out  add point or read-and-clear bin
//  result    done, result              out        one bin report per read
//
//  A point needing CORDIC holds the engine for the vectoring loop, then a
//  reciprocal divide by the gain (cut short after its saturation check when
//  the range saturates), then binning and the bin update; points on an axis
//  skip to binning, and reads go to the bin fetch and the report. A request
//  waits in the two-entry queue until the engine is idle, so requests can be
//  taken while the engine works. After reset the bin store is cleared one
//  entry a cycle with busy high. Results are a one-cycle done strobe.
// ----------------------------------------------------------------------------
module point_cloud_to_polar_min_scan_top #(
  parameter int ANGLE_BINS   = pcpolar_pkg::ANGLE_BINS_DEF,
  parameter int COORD_WIDTH  = pcpolar_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = pcpolar_pkg::CORDIC_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pcpolar_pkg::req_t cmd,
  output logic              done,
  output pcpolar_pkg::res_t result
);
  import pcpolar_pkg::*;

  entry_t        fe_entry;
  entry_t        q_head;
  queue_status_t qstat;
  back_status_t  bstat;
  logic          push;
  logic          pop;

  assign busy = bstat.clearing || qstat.full;
  assign push = start && !busy;

  pcpolar_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .cmd   (cmd),
    .entry (fe_entry)
  );

  pcpolar_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .din    (fe_entry),
    .pop    (pop),
    .dout   (q_head),
    .status (qstat)
  );

  pcpolar_back #(
    .ANGLE_BINS   (ANGLE_BINS),
    .COORD_WIDTH  (COORD_WIDTH),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (qstat.empty),
    .q_head  (q_head),
    .pop     (pop),
    .done    (done),
    .result  (result),
    .status  (bstat)
  );

`ifndef SYNTHESIS
  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (rst)
    bstat.clearing |-> !done) else $error("result during clearing pass");
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.count != 2'd3) else $error("queue count overflow");
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty) else $error("queue pop while empty");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> bstat.idle) else $error("queue pop while engine busy");
`endif

endmodule

/* verif/point_cloud_to_polar_min_scan_top_tb.sv */
// ----------------------------------------------------------------------------
// point_cloud_to_polar_min_scan_top_tb
// Self-checking bench: directed table of points and bin reads, then random
// clustered scans. A local CORDIC model of the bin store predicts each read.
// ----------------------------------------------------------------------------
module point_cloud_to_polar_min_scan_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pcpolar_pkg::*;

  localparam int NBINS = ANGLE_BINS_DEF;
  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam int CYCLE_LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t cmd = '0;
  logic done;
  res_t result;

  point_cloud_to_polar_min_scan_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .done(done), .result(result)
  );

  always #5 clk = ~clk;

  logic [24:0] scan_bins [NBINS] = '{default: '0};
  res_t reports_due [$];
  int errors = 0;
  int cycles = 0;
  logic [63:0] gain_q;
  int quiet_from, quiet_to, item_no;

  localparam logic [31:0] TAB [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  function automatic logic [63:0] root64(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [23:0] clip(input logic [63:0] r);
    return (r > 64'hFFFFFF) ? 24'hFFFFFF : r[23:0];
  endfunction

  // fold one point into the predicted scan
  task automatic fold_point(input logic signed [23:0] xi, input logic signed [23:0] yi);
    longint x, y, cx, cy, dx, dy;
    logic [31:0] z;
    logic [23:0] rng;
    logic [63:0] xf, b;
    x = xi;
    y = yi;
    z = 0;
    if (y == 0) begin
      rng = clip(x < 0 ? -x : x);
      z = x < 0 ? 32'h8000_0000 : 32'h0;
    end else if (x == 0) begin
      rng = clip(y < 0 ? -y : y);
      z = y < 0 ? 32'hC000_0000 : 32'h4000_0000;
    end else begin
      cx = x * 16;
      cy = y * 16;
      if (cx < 0) begin
        cx = -cx;
        cy = -cy;
        z = 32'h8000_0000;
      end
      for (int i = 0; i < STEPS; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy >= 0) begin
          cx += dx; cy -= dy; z += TAB[5'(i)];
        end else begin
          cx -= dx; cy += dy; z -= TAB[5'(i)];
        end
      end
      xf = cx > 0 ? cx : 0;
      rng = clip(((xf << 26) + gain_q / 2) / gain_q);
    end
    b = ({32'd0, z + 32'h8000_0000} * NBINS) >> 32;
    if (!scan_bins[b[10:0]][24] || rng < scan_bins[b[10:0]][23:0])
      scan_bins[b[10:0]] = {1'b1, rng};
  endtask

  function automatic res_t read_bin_out(input logic [10:0] bn);
    res_t r;
    r = '0;
    r.bin_number = bn;
    if (bn < NBINS) begin
      if (scan_bins[bn][24]) begin
        r.bin_range = scan_bins[bn][23:0];
        r.bin_hit = 1'b1;
      end
      scan_bins[bn] = '0;
    end
    return r;
  endfunction

  // issue one request, wait for acceptance, update prediction
  task automatic issue(input req_t c, input bit idle_ok);
    res_t r;
    if (idle_ok) begin
      while ($urandom_range(99) < 21) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    cmd <= c;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (c.opcode == OP_ADD) fold_point(c.x_coord, c.y_coord);
    else begin
      r = read_bin_out(c.read_bin);
      reports_due.push_back(r);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  always @(posedge clk) begin
    res_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
    if (!rst && done) begin
      if (reports_due.size() == 0) begin
        $error("unexpected report for bin %0d", result.bin_number);
        errors++;
      end else begin
        e = reports_due.pop_front();
        if (e.bin_range !== result.bin_range) begin
          $error("bin_range exp %0d got %0d", e.bin_range, result.bin_range); errors++;
        end
        if (e.bin_hit !== result.bin_hit) begin
          $error("bin_hit exp %0d got %0d", e.bin_hit, result.bin_hit); errors++;
        end
        if (e.bin_number !== result.bin_number) begin
          $error("bin_number exp %0d got %0d", e.bin_number, result.bin_number); errors++;
        end
      end
    end
  end

  function automatic req_t mk(input logic op, input int x, input int y, input int bn);
    req_t c;
    c.opcode = op;
    c.x_coord = 24'(x);
    c.y_coord = 24'(y);
    c.read_bin = 11'(bn);
    return c;
  endfunction

  typedef struct {
    req_t c;
    bit   known;
    res_t r;
  } row_t;

  row_t plan [$];
  res_t typed;

  function automatic res_t rpt(input int rg, input bit h, input int bn);
    res_t r;
    r.bin_range = 24'(rg);
    r.bin_hit = h;
    r.bin_number = 11'(bn);
    return r;
  endfunction

  task automatic row(input req_t c, input bit k, input res_t r);
    row_t w;
    w.c = c; w.known = k; w.r = r;
    plan.push_back(w);
  endtask

  initial begin
    req_t c;
    int cnt, centre, spread;
    bit mid_drained;
    mid_drained = 1'b0;
    begin : gain_calc
      logic [63:0] g;
      g = 64'd1 << 30;
      for (int i = 0; i < STEPS; i++) g = g + (g >> (2 * i));
      gain_q = root64(g << 30);
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table: reset state, axes, origin, pi wrap, extremes, bad bin
    row(mk(OP_READ, 0, 0, 0), 1, rpt(0, 0, 0));
    row(mk(OP_READ, 0, 0, 1439), 1, rpt(0, 0, 1439));
    row(mk(OP_ADD, 0, 0, 0), 0, '0);
    row(mk(OP_READ, 0, 0, 720), 1, rpt(0, 1, 720));
    row(mk(OP_ADD, -5, 0, 0), 0, '0);
    row(mk(OP_READ, 0, 0, 0), 1, rpt(5, 1, 0));
    row(mk(OP_ADD, 8388607, 0, 0), 0, '0);
    row(mk(OP_ADD, 100, 0, 0), 0, '0);
    row(mk(OP_READ, 0, 0, 720), 1, rpt(100, 1, 720));
    row(mk(OP_ADD, 0, -8388608, 0), 0, '0);
    row(mk(OP_READ, 0, 0, 360), 1, rpt(8388608, 1, 360));
    row(mk(OP_ADD, 0, 8388607, 0), 0, '0);
    row(mk(OP_READ, 0, 0, 1080), 1, rpt(8388607, 1, 1080));
    row(mk(OP_ADD, -8388608, -8388608, 0), 0, '0);
    row(mk(OP_ADD, 8388607, 8388607, 0), 0, '0);
    row(mk(OP_ADD, -8388608, 8388607, 0), 0, '0);
    row(mk(OP_ADD, 8388607, -8388608, 0), 0, '0);
    row(mk(OP_ADD, 3, 4, 0), 0, '0);
    row(mk(OP_READ, 0, 0, 180), 0, '0);
    row(mk(OP_READ, 0, 0, 900), 0, '0);
    row(mk(OP_READ, 0, 0, 1260), 0, '0);
    row(mk(OP_READ, 0, 0, 540), 0, '0);
    row(mk(OP_READ, 0, 0, 2047), 1, rpt(0, 0, 2047));
    row(mk(OP_READ, 0, 0, 1440), 1, rpt(0, 0, 1440));
    foreach (plan[i]) begin
      issue(plan[i].c, 0);
      if (plan[i].known) begin
        typed = reports_due[$];
        if (typed !== plan[i].r) begin
          $error("table row %0d: report exp %h got %h", i, plan[i].r, typed);
          errors++;
        end
      end
    end
    drain();

    // random scans: clusters of points near one angle, then batches of reads of random bins
    item_no = 0;
    quiet_from = 150;
    quiet_to = 400;
    while (item_no < 540) begin
      if (!mid_drained && item_no >= 280) begin
        drain();
        mid_drained = 1'b1;
      end
      cnt = $urandom_range(20, 1);
      spread = $urandom_range(3) == 0 ? 8388607 : $urandom_range(4000, 1);
      centre = $urandom;
      for (int k = 0; k < cnt; k++) begin
        c = '0;
        c.opcode = OP_ADD;
        if ($urandom_range(9) == 0) begin
          c.x_coord = 24'($urandom);
          c.y_coord = 24'($urandom);
        end else begin
          c.x_coord = 24'($signed(centre[23:0]) / (($urandom_range(3) == 0) ? 1 : 256)
                      + $signed($urandom_range(2 * spread) - spread) / 16);
          c.y_coord = 24'($signed({centre[7:0], centre[31:16]}) / 256 +
                      $signed($urandom_range(2 * spread) - spread) / 16);
          if ($urandom_range(15) == 0) c.y_coord = 0;
          if ($urandom_range(15) == 0) c.x_coord = 0;
        end
        c.read_bin = 11'($urandom);
        issue(c, item_no < quiet_from || item_no > quiet_to);
        item_no++;
      end
      cnt = $urandom_range(12, 1);
      for (int k = 0; k < cnt; k++) begin
        c = '0;
        c.opcode = OP_READ;
        c.x_coord = 24'($urandom);
        c.y_coord = 24'($urandom);
        c.read_bin = 11'(($urandom_range(19) == 0) ? $urandom : $urandom_range(NBINS - 1));
        issue(c, item_no < quiet_from || item_no > quiet_to);
        item_no++;
      end
    end
    // sweep every bin once to catch stray writes
    for (int b = 0; b < NBINS; b++) begin
      issue(mk(OP_READ, 0, 0, b), 1);
    end
    drain();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
